>>> sv/ansi_text_console_engine_assert.svh
// ----------------------------------------------------------------------------
// ansi text console engine assertion macros
// Concurrent check macros; they expand to nothing in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef ANSI_TEXT_CONSOLE_ENGINE_ASSERT_SVH
`define ANSI_TEXT_CONSOLE_ENGINE_ASSERT_SVH
`ifndef SYNTHESIS
// expression holds at every edge out of reset
`define ATCE_CHECK(label, clk, rstn, expr) \
	label: assert property (@(posedge clk) disable iff (!rstn) (expr)) \
		else $error("atce check failed");
// antecedent implies consequent in the same cycle
`define ATCE_IMPLIES(label, clk, rstn, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("atce implication failed");
// antecedent implies consequent in the next cycle
`define ATCE_NEXT(label, clk, rstn, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("atce next-cycle check failed");
`else
`define ATCE_CHECK(label, clk, rstn, expr)
`define ATCE_IMPLIES(label, clk, rstn, ante, cons)
`define ATCE_NEXT(label, clk, rstn, ante, cons)
`endif
`endif

>>> sv/atce_pkg.sv
// ----------------------------------------------------------------------------
// atce_pkg
// Shared types and constants of the ansi text console engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package atce_pkg;

	// parser state
	typedef enum logic [1:0] {
		MODE_NORMAL  = 2'd0,
		MODE_ESC     = 2'd1,
		MODE_BRACKET = 2'd2,
		MODE_PARAM   = 2'd3
	} parse_mode_t;

	// command codes on the output
	typedef enum logic [1:0] {
		ACT_DRAW   = 2'd0,
		ACT_SCROLL = 2'd1,
		ACT_CLEAR  = 2'd2
	} action_t;

	// input item kinds
	localparam logic [1:0] KIND_BYTE   = 2'd0;
	localparam logic [1:0] KIND_COLORS = 2'd1;
	localparam logic [1:0] KIND_CLEAR  = 2'd2;

	// configuration register indexes
	localparam logic [1:0] REG_COLUMNS  = 2'd0;
	localparam logic [1:0] REG_ROWS     = 2'd1;
	localparam logic [1:0] REG_DEF_FORE = 2'd2;
	localparam logic [1:0] REG_DEF_BACK = 2'd3;

	// register reset values
	localparam logic [8:0]  COLUMNS_RST  = 9'd128;
	localparam logic [6:0]  ROWS_RST     = 7'd48;
	localparam logic [31:0] DEF_FORE_RST = 32'h00FF_FFFF;
	localparam logic [31:0] DEF_BACK_RST = 32'h0000_0000;

	// console bytes
	localparam logic [7:0] CH_ESC    = 8'h1B;
	localparam logic [7:0] CH_NL     = 8'h0A;
	localparam logic [7:0] CH_BS     = 8'h08;
	localparam logic [7:0] CH_LBRACK = 8'h5B;
	localparam logic [7:0] CH_SEMI   = 8'h3B;
	localparam logic [7:0] CH_SGR    = 8'h6D;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;
	localparam logic [7:0] CH_SPACE  = 8'h20;

	// sgr codes
	localparam logic [6:0] SGR_FG_LO = 7'd30;
	localparam logic [6:0] SGR_FG_HI = 7'd37;
	localparam logic [6:0] SGR_BG_LO = 7'd40;
	localparam logic [6:0] SGR_BG_HI = 7'd47;
	localparam logic [6:0] SGR_SAT   = 7'd100;

	localparam logic [31:0] SGR_PALETTE [8] = '{
		32'h0000_0000, 32'h00FF_0000, 32'h0000_FF00, 32'h00FF_FF00,
		32'h0000_00FF, 32'h00FF_00FF, 32'h0000_FFFF, 32'h00FF_FFFF
	};

	// job queue between front and back
	localparam int QDEPTH = 2;
	localparam int QAW    = 1;
	localparam int QCW    = 2;

	typedef struct packed {
		action_t     action;
		logic [7:0]  column;
		logic [5:0]  row;
		logic [7:0]  glyph;
		logic [31:0] ink;
		logic [31:0] paper;
	} cmd_t;

	// one item's work: a first command and an optional trailing scroll
	typedef struct packed {
		cmd_t        first;
		logic        scroll;
		logic [5:0]  scroll_row;
		logic [31:0] scroll_paper;
	} job_t;

	// queue status seen by front and back
	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

endpackage

>>> sv/atce_front.sv
// ----------------------------------------------------------------------------
// atce_front
// Accepts items, runs the escape parser and cursor, and queues command jobs.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module atce_front #(
	parameter int MAX_COLUMNS    = 256,
	parameter int MAX_ROWS       = 64,
	parameter int PARAM_BUF_SIZE = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [1:0]          cfg_index,
	input  logic [31:0]         cfg_data,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [1:0]          kind,
	input  logic [7:0]          char_byte,
	input  logic [31:0]         fore_value,
	input  logic [31:0]         back_value,
	input  atce_pkg::q_status_t q_status,
	output logic                push,
	output atce_pkg::job_t      job
);

	localparam int CW = $clog2(MAX_COLUMNS + 1);
	localparam int RW = $clog2(MAX_ROWS + 1);
	localparam int LW = $clog2(MAX_ROWS);
	localparam int DW = $clog2(PARAM_BUF_SIZE);
	localparam logic [DW-1:0] DC_MAX = DW'(PARAM_BUF_SIZE - 1);

	logic [8:0]  text_columns_q;
	logic [6:0]  text_rows_q;
	logic [31:0] def_fore_q;
	logic [31:0] def_back_q;

	atce_pkg::parse_mode_t mode_q, mode_n;
	logic [6:0]    pv_q, pv_n;
	logic [DW-1:0] dc_q, dc_n;
	logic [CW-1:0] col_q, col_n, col_a;
	logic [LW-1:0] line_q, line_n;
	logic [31:0]   fore_q, fore_n, back_q, back_n;

	logic [CW-1:0] cols_eff;
	logic [RW-1:0] rows_eff;
	logic [LW-1:0] rows_last;
	logic          acc;
	logic          is_digit;
	logic [9:0]    dig_sum;
	logic [6:0]    dig_val;
	logic          sgr_go;
	logic [6:0]    sgr_p;
	logic [6:0]    sgr_off;
	logic          draw, clear, nl, scroll;
	atce_pkg::cmd_t draw_cmd, scroll_cmd;

	assign in_ready = !q_status.full;
	assign acc      = in_valid && in_ready;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			text_columns_q <= atce_pkg::COLUMNS_RST;
			text_rows_q    <= atce_pkg::ROWS_RST;
			def_fore_q     <= atce_pkg::DEF_FORE_RST;
			def_back_q     <= atce_pkg::DEF_BACK_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				atce_pkg::REG_COLUMNS:  text_columns_q <= cfg_data[8:0];
				atce_pkg::REG_ROWS:     text_rows_q    <= cfg_data[6:0];
				atce_pkg::REG_DEF_FORE: def_fore_q     <= cfg_data;
				atce_pkg::REG_DEF_BACK: def_back_q     <= cfg_data;
				default: ;
			endcase
		end
	end

	// clamped screen geometry
	always_comb begin
		if (text_columns_q == '0)
			cols_eff = CW'(1);
		else if (32'(text_columns_q) > 32'(MAX_COLUMNS))
			cols_eff = CW'(MAX_COLUMNS);
		else
			cols_eff = CW'(text_columns_q);
		if (text_rows_q == '0)
			rows_eff = RW'(1);
		else if (32'(text_rows_q) > 32'(MAX_ROWS))
			rows_eff = RW'(MAX_ROWS);
		else
			rows_eff = RW'(text_rows_q);
	end
	assign rows_last = LW'(rows_eff - RW'(1));

	// decimal accumulator with saturation
	assign is_digit = (char_byte >= atce_pkg::CH_ZERO) && (char_byte <= atce_pkg::CH_NINE);
	assign dig_sum  = 10'(pv_q) * 10'd10 + 10'(char_byte[3:0]);
	assign dig_val  = (dig_sum > 10'(atce_pkg::SGR_SAT)) ? atce_pkg::SGR_SAT : dig_sum[6:0];

	// parser, colour and cursor next state
	always_comb begin
		mode_n  = mode_q;
		pv_n    = pv_q;
		dc_n    = dc_q;
		col_a   = col_q;
		line_n  = line_q;
		fore_n  = fore_q;
		back_n  = back_q;
		sgr_go  = 1'b0;
		sgr_p   = pv_q;
		sgr_off = '0;
		draw    = 1'b0;
		clear   = 1'b0;
		nl      = 1'b0;
		scroll  = 1'b0;
		draw_cmd = '{action: atce_pkg::ACT_DRAW, column: 8'(col_q), row: 6'(line_q),
		             glyph: char_byte, ink: fore_q, paper: back_q};
		case (kind)
			atce_pkg::KIND_COLORS: begin
				fore_n = fore_value;
				back_n = back_value;
			end
			atce_pkg::KIND_CLEAR: begin
				fore_n = fore_value;
				back_n = back_value;
				col_a  = '0;
				line_n = '0;
				clear  = 1'b1;
				draw_cmd = '{action: atce_pkg::ACT_CLEAR, column: 8'd0, row: 6'd0,
				             glyph: 8'd0, ink: 32'd0, paper: back_value};
			end
			atce_pkg::KIND_BYTE: begin
				unique case (mode_q)
					atce_pkg::MODE_ESC: begin
						if (char_byte == atce_pkg::CH_LBRACK) begin
							mode_n = atce_pkg::MODE_BRACKET;
							pv_n   = '0;
							dc_n   = '0;
						end else begin
							mode_n = atce_pkg::MODE_NORMAL;
						end
					end
					atce_pkg::MODE_BRACKET, atce_pkg::MODE_PARAM: begin
						if (is_digit) begin
							mode_n = atce_pkg::MODE_PARAM;
							if (dc_q < DC_MAX) begin
								pv_n = dig_val;
								dc_n = dc_q + DW'(1);
							end
						end else if (char_byte == atce_pkg::CH_SEMI &&
						             mode_q == atce_pkg::MODE_PARAM) begin
							sgr_go = 1'b1;
							pv_n   = '0;
							dc_n   = '0;
						end else if (char_byte == atce_pkg::CH_SGR) begin
							sgr_go = 1'b1;
							if (mode_q == atce_pkg::MODE_BRACKET) begin
								sgr_p = '0;
								pv_n  = '0;
							end
							mode_n = atce_pkg::MODE_NORMAL;
						end else begin
							mode_n = atce_pkg::MODE_NORMAL;
						end
					end
					default: begin
						if (char_byte == atce_pkg::CH_ESC) begin
							mode_n = atce_pkg::MODE_ESC;
						end else if (char_byte == atce_pkg::CH_NL) begin
							nl = 1'b1;
						end else if (char_byte == atce_pkg::CH_BS) begin
							if (col_q != '0) begin
								col_a = col_q - CW'(1);
								draw  = 1'b1;
								draw_cmd = '{action: atce_pkg::ACT_DRAW,
								             column: 8'(col_q - CW'(1)), row: 6'(line_q),
								             glyph: atce_pkg::CH_SPACE, ink: back_q,
								             paper: back_q};
							end
						end else if (col_q < cols_eff) begin
							draw  = 1'b1;
							col_a = col_q + CW'(1);
						end
					end
				endcase
				// sgr action
				sgr_off = (sgr_p >= atce_pkg::SGR_BG_LO) ? sgr_p - atce_pkg::SGR_BG_LO
				                                          : sgr_p - atce_pkg::SGR_FG_LO;
				if (sgr_go) begin
					if (sgr_p == '0) begin
						fore_n = def_fore_q;
						back_n = def_back_q;
					end else if (sgr_p >= atce_pkg::SGR_FG_LO &&
					             sgr_p <= atce_pkg::SGR_FG_HI) begin
						fore_n = atce_pkg::SGR_PALETTE[sgr_off[2:0]];
					end else if (sgr_p >= atce_pkg::SGR_BG_LO &&
					             sgr_p <= atce_pkg::SGR_BG_HI) begin
						back_n = atce_pkg::SGR_PALETTE[sgr_off[2:0]];
					end
				end
				// end of row wraps
				if (col_a >= cols_eff)
					nl = 1'b1;
				if (nl) begin
					col_a = '0;
					if (line_q < rows_last) begin
						line_n = line_q + LW'(1);
					end else begin
						line_n = rows_last;
						scroll = 1'b1;
					end
				end
			end
			default: ;
		endcase
		col_n = col_a;
		scroll_cmd = '{action: atce_pkg::ACT_SCROLL, column: 8'd0, row: 6'(rows_last),
		               glyph: 8'd0, ink: 32'd0, paper: back_n};
	end

	// job for the back end
	always_comb begin
		job.first        = (draw || clear) ? draw_cmd : scroll_cmd;
		job.scroll       = draw && scroll;
		job.scroll_row   = scroll_cmd.row;
		job.scroll_paper = scroll_cmd.paper;
	end
	assign push = acc && (draw || clear || scroll);

	// front state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= atce_pkg::MODE_NORMAL;
			pv_q   <= '0;
			dc_q   <= '0;
			col_q  <= '0;
			line_q <= '0;
			fore_q <= atce_pkg::DEF_FORE_RST;
			back_q <= atce_pkg::DEF_BACK_RST;
		end else if (acc) begin
			mode_q <= mode_n;
			pv_q   <= pv_n;
			dc_q   <= dc_n;
			col_q  <= col_n;
			line_q <= line_n;
			fore_q <= fore_n;
			back_q <= back_n;
		end
	end

endmodule

>>> sv/atce_queue.sv
// ----------------------------------------------------------------------------
// atce_queue
// Short job queue that decouples the front from the back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "ansi_text_console_engine_assert.svh"

module atce_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  atce_pkg::job_t      wr_job,
	input  logic                pop,
	output atce_pkg::job_t      rd_job,
	output atce_pkg::q_status_t status
);

	atce_pkg::job_t                 slot_q [atce_pkg::QDEPTH];
	logic [atce_pkg::QAW-1:0] wr_ptr_q, rd_ptr_q;
	logic [atce_pkg::QCW-1:0] count_q;

	assign status.full  = (count_q == atce_pkg::QCW'(atce_pkg::QDEPTH));
	assign status.empty = (count_q == '0);
	assign rd_job       = slot_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (push)
			slot_q[wr_ptr_q] <= wr_job;
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + atce_pkg::QAW'(1);
			if (pop)
				rd_ptr_q <= rd_ptr_q + atce_pkg::QAW'(1);
			if (push && !pop)
				count_q <= count_q + atce_pkg::QCW'(1);
			else if (pop && !push)
				count_q <= count_q - atce_pkg::QCW'(1);
		end
	end

	`ATCE_CHECK(a_count_bound, clk, arst_n, count_q <= atce_pkg::QCW'(atce_pkg::QDEPTH))
	`ATCE_IMPLIES(a_no_push_full, clk, arst_n, push, !status.full)
	`ATCE_IMPLIES(a_no_pop_empty, clk, arst_n, pop, !status.empty)

endmodule

>>> sv/atce_back.sv
// ----------------------------------------------------------------------------
// atce_back
// Unrolls queued jobs into command beats behind a registered output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "ansi_text_console_engine_assert.svh"

module atce_back (
	input  logic                clk,
	input  logic                arst_n,
	input  atce_pkg::job_t      job,
	input  atce_pkg::q_status_t q_status,
	output logic                pop,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [1:0]          action,
	output logic [7:0]          cell_column,
	output logic [5:0]          cell_row,
	output logic [7:0]          glyph,
	output logic [31:0]         ink_color,
	output logic [31:0]         paper_color,
	output logic                last
);

	atce_pkg::cmd_t out_q, scroll_q, job_scroll;
	logic           valid_q, last_q, pend_q;
	logic           load;

	assign load = !valid_q || out_ready;
	assign pop  = load && !pend_q && !q_status.empty;

	assign job_scroll = '{action: atce_pkg::ACT_SCROLL, column: 8'd0, row: job.scroll_row,
	                      glyph: 8'd0, ink: 32'd0, paper: job.scroll_paper};

	// beat control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			last_q  <= 1'b0;
			pend_q  <= 1'b0;
		end else if (load) begin
			if (pend_q) begin
				valid_q <= 1'b1;
				last_q  <= 1'b1;
				pend_q  <= 1'b0;
			end else if (!q_status.empty) begin
				valid_q <= 1'b1;
				last_q  <= !job.scroll;
				pend_q  <= job.scroll;
			end else begin
				valid_q <= 1'b0;
			end
		end
	end

	// beat payload
	always_ff @(posedge clk) begin
		if (load) begin
			if (pend_q) begin
				out_q <= scroll_q;
			end else if (!q_status.empty) begin
				out_q    <= job.first;
				scroll_q <= job_scroll;
			end
		end
	end

	assign out_valid   = valid_q;
	assign action      = out_q.action;
	assign cell_column = out_q.column;
	assign cell_row    = out_q.row;
	assign glyph       = out_q.glyph;
	assign ink_color   = out_q.ink;
	assign paper_color = out_q.paper;
	assign last        = last_q;

	`ATCE_IMPLIES(a_pend_holds_first, clk, arst_n, pend_q, valid_q && !last_q)
	`ATCE_NEXT(a_scroll_follows, clk, arst_n, pend_q && out_ready,
		valid_q && last_q && out_q.action == atce_pkg::ACT_SCROLL)

endmodule

>>> sv/ansi_text_console_engine.sv
// ----------------------------------------------------------------------------
// ansi_text_console_engine
// Console byte stream to character-cell drawing commands, with SGR colours.
// ----------------------------------------------------------------------------
// Takes one item per clock while the job queue is not full. A byte gives at
// most two command beats (a cell draw and a scroll); the output register
// sends one beat per clock while out_ready allows, so a run of bytes that
// each wrap on the bottom row is paced by that single output stage.
// Configuration must be written with the block idle; it is not enforced.
`timescale 1ns / 1ps

module ansi_text_console_engine #(
	parameter int MAX_COLUMNS    = 256,
	parameter int MAX_ROWS       = 64,
	parameter int PARAM_BUF_SIZE = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  kind,
	input  logic [7:0]  char_byte,
	input  logic [31:0] fore_value,
	input  logic [31:0] back_value,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  action,
	output logic [7:0]  cell_column,
	output logic [5:0]  cell_row,
	output logic [7:0]  glyph,
	output logic [31:0] ink_color,
	output logic [31:0] paper_color,
	output logic        last
);

	atce_pkg::job_t      push_job, head_job;
	atce_pkg::q_status_t q_status;
	logic                push, pop;

	// parser and cursor
	atce_front #(
		.MAX_COLUMNS   (MAX_COLUMNS),
		.MAX_ROWS      (MAX_ROWS),
		.PARAM_BUF_SIZE(PARAM_BUF_SIZE)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.kind      (kind),
		.char_byte (char_byte),
		.fore_value(fore_value),
		.back_value(back_value),
		.q_status  (q_status),
		.push      (push),
		.job       (push_job)
	);

	// job queue
	atce_queue u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.wr_job(push_job),
		.pop   (pop),
		.rd_job(head_job),
		.status(q_status)
	);

	// command beats
	atce_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.job        (head_job),
		.q_status   (q_status),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.action     (action),
		.cell_column(cell_column),
		.cell_row   (cell_row),
		.glyph      (glyph),
		.ink_color  (ink_color),
		.paper_color(paper_color),
		.last       (last)
	);

endmodule
